[sv/dmc_pkg.sv]
package dmc_pkg;

  localparam int unsigned CFG_W      = 4;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned OFF_MIN    = 4;
  localparam int unsigned OFF_MAX    = 8;
  localparam int unsigned IDX_MAX    = 10;
  localparam int unsigned RECIP_SH   = 20;

  localparam logic [CFG_W-1:0]   OFF_RESET = 4'd4;
  localparam logic [CFG_W-1:0]   IDX_RESET = 4'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    REG_OFFSET_BITS = 1'b0,
    REG_INDEX_BITS  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic quot;
    logic rem;
    logic fix;
    logic read;
    logic finish;
    logic clear;
  } dmc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dmc_status_t;

endpackage

[sv/direct_mapped_cache_hit_check.sv]
// Channel  Direction  Handshake                Payload
// cfg      in         cfg_we_i                 cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_stall_o  address_i
// out      out        out_valid_o / out_stall_i  hit_o, line_index_o, access_total_o,
//                                              miss_total_o
//
// A transfer is accepted only while idle; its result then passes through these steps: quotient
// multiply, remainder multiply, wrap, tag memory read, compare and update.
// No new transfer is accepted until the last one has finished its update step.
// After reset the tag memory is swept clear, one line at a time, before the first transfer.
// The result register lets a new transfer in while the last result is stalled; the
// update step waits until that register frees up.
module direct_mapped_cache_hit_check #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned MAX_LINES  = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dmc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ADDR_WIDTH-1:0]       address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [dmc_pkg::IDX_W-1:0]   line_index_o,
  output logic [dmc_pkg::COUNT_W-1:0] access_total_o,
  output logic [dmc_pkg::COUNT_W-1:0] miss_total_o
);
  import dmc_pkg::*;

  dmc_cmd_t    cmd;
  dmc_status_t status;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmc_datapath #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .MAX_LINES  (MAX_LINES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .address_i      (address_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .access_total_o (access_total_o),
    .miss_total_o   (miss_total_o)
  );

endmodule

[sv/dmc_ctrl.sv]
module dmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dmc_pkg::dmc_status_t status_i,
  output dmc_pkg::dmc_cmd_t    cmd_o
);
  import dmc_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_QUOT  = 7'b0000100,
    ST_REM   = 7'b0001000,
    ST_FIX   = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_CHECK = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/dmc_datapath.sv]
module dmc_datapath #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned MAX_LINES  = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [dmc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [ADDR_WIDTH-1:0]            address_i,
  input  dmc_pkg::dmc_cmd_t                cmd_i,
  output dmc_pkg::dmc_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [dmc_pkg::IDX_W-1:0]        line_index_o,
  output logic [dmc_pkg::COUNT_W-1:0]      access_total_o,
  output logic [dmc_pkg::COUNT_W-1:0]      miss_total_o
);
  import dmc_pkg::*;

  localparam int unsigned TAG_W   = ADDR_WIDTH - OFF_MIN;
  localparam int unsigned LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned RECIP   = (1 << RECIP_SH) / MAX_LINES;
  localparam int unsigned RECIP_W = RECIP_SH + 1;
  localparam int unsigned LINES_W = $clog2(MAX_LINES + 1) + 1;
  localparam int unsigned PROD_W  = IDX_W + LINES_W;

  logic [CFG_W-1:0]   off_q, idx_bits_q;
  logic [IDX_W-1:0]   idx_q, quot_q, rem_q;
  logic [TAG_W-1:0]   tag_q;
  logic [LINE_W-1:0]  line_q, clr_q;
  logic [TAG_W:0]     rd_q;
  logic [TAG_W:0]     mem_q [MAX_LINES];
  logic [COUNT_W-1:0] acc_q, miss_q;
  logic               out_valid_q, out_hit_q;
  logic [IDX_W-1:0]   out_line_q;

  logic [CFG_W-1:0]             cfg_sat;
  logic [CFG_W:0]               split;
  logic [IDX_W:0]               idx_mask;
  logic [IDX_W-1:0]             idx_d, line_fix;
  logic [TAG_W-1:0]             tag_d;
  logic [IDX_W+RECIP_W-1:0]     quot_prod;
  logic [PROD_W-1:0]            back_prod;
  logic [PROD_W-1:0]            rem_wide;
  logic                         hit;

  always_comb begin
    cfg_sat = cfg_data_i;
    if (cfg_idx_i == REG_OFFSET_BITS) begin
      if (cfg_data_i < CFG_W'(OFF_MIN)) cfg_sat = CFG_W'(OFF_MIN);
      if (cfg_data_i > CFG_W'(OFF_MAX)) cfg_sat = CFG_W'(OFF_MAX);
    end else begin
      if (cfg_data_i > CFG_W'(IDX_MAX)) cfg_sat = CFG_W'(IDX_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= OFF_RESET;
      idx_bits_q <= IDX_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_OFFSET_BITS) off_q <= cfg_sat;
      else                              idx_bits_q <= cfg_sat;
    end
  end

  assign split     = {1'b0, off_q} + {1'b0, idx_bits_q};
  assign idx_mask  = (IDX_W+1)'((IDX_W+1)'(1) << idx_bits_q) - (IDX_W+1)'(1);
  assign idx_d     = IDX_W'(address_i >> off_q) & idx_mask[IDX_W-1:0];
  assign tag_d     = TAG_W'(address_i >> split);
  assign quot_prod = (IDX_W+RECIP_W)'(idx_q) * (IDX_W+RECIP_W)'(RECIP);
  assign back_prod = PROD_W'(quot_q) * PROD_W'(MAX_LINES);
  assign rem_wide  = PROD_W'(idx_q) - back_prod;
  assign line_fix  = (PROD_W'(rem_q) >= PROD_W'(MAX_LINES))
                     ? rem_q - IDX_W'(MAX_LINES) : rem_q;
  assign hit       = rd_q[TAG_W] && (rd_q[TAG_W-1:0] == tag_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= idx_d;
      tag_q <= tag_d;
    end
    if (cmd_i.quot) quot_q <= IDX_W'(quot_prod >> RECIP_SH);
    if (cmd_i.rem)  rem_q  <= rem_wide[IDX_W-1:0];
    if (cmd_i.fix)  line_q <= LINE_W'(line_fix);
    if (cmd_i.read) rd_q   <= mem_q[line_q];
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.finish && !hit) begin
      mem_q[line_q] <= {1'b1, tag_q};
    end
    if (cmd_i.finish) begin
      out_hit_q  <= hit;
      out_line_q <= IDX_W'(line_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + LINE_W'(1);
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (acc_q != COUNT_MAX) acc_q <= acc_q + COUNT_W'(1);
        if (!hit && miss_q != COUNT_MAX) miss_q <= miss_q + COUNT_W'(1);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last = (clr_q == LINE_W'(MAX_LINES - 1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign line_index_o   = out_line_q;
  assign access_total_o = acc_q;
  assign miss_total_o   = miss_q;

endmodule

[tb/dmc_lookup_checker.sv]
`timescale 1ns / 1ps
module dmc_lookup_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dmc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [31:0]                 address_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        hit_i,
  input  logic [dmc_pkg::IDX_W-1:0]   line_index_i,
  input  logic [dmc_pkg::COUNT_W-1:0] access_total_i,
  input  logic [dmc_pkg::COUNT_W-1:0] miss_total_i,
  output int                          error_count_o,
  output int                          pending_o,
  output int                          result_count_o,
  output int                          hit_count_o
);
  import dmc_pkg::*;

  localparam int unsigned LINES = 1024;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   line;
    logic [COUNT_W-1:0] accesses;
    logic [COUNT_W-1:0] misses;
  } lookup_t;

  lookup_t            expected_lookups[$];
  logic               line_valid[LINES];
  logic [31:0]        line_tag[LINES];
  logic [COUNT_W-1:0] access_count;
  logic [COUNT_W-1:0] miss_count;
  logic [CFG_W-1:0]   offset_bits;
  logic [CFG_W-1:0]   index_bits;
  int                 errors = 0;
  int                 outstanding = 0;
  int                 results = 0;
  int                 hits = 0;

  assign error_count_o  = errors;
  assign pending_o      = outstanding;
  assign result_count_o = results;
  assign hit_count_o    = hits;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic lookup_t predict_lookup(input logic [31:0] addr);
    lookup_t     res;
    logic [31:0] tag;
    logic [31:0] sel;
    tag = addr >> (int'(offset_bits) + int'(index_bits));
    sel = (addr >> offset_bits) & ((32'd1 << index_bits) - 32'd1);
    // the index never exceeds the store, so it is used as the line as it is
    res.line = sel[IDX_W-1:0];
    res.hit = line_valid[res.line] && (line_tag[res.line] == tag);
    access_count = bump(access_count);
    if (!res.hit) begin
      miss_count = bump(miss_count);
      line_valid[res.line] = 1'b1;
      line_tag[res.line] = tag;
    end
    res.accesses = access_count;
    res.misses = miss_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t exp_l;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;
      access_count = '0;
      miss_count = '0;
      offset_bits = OFF_RESET;
      index_bits = IDX_RESET;
      expected_lookups.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result: hit %0b, line %0h, accesses %0h, misses %0h",
                   $time, hit_i, line_index_i, access_total_i, miss_total_i);
          errors++;
        end else begin
          exp_l = expected_lookups.pop_front();
          if (exp_l.hit) hits++;
          check_field("hit", exp_l.hit, hit_i);
          check_field("line_index", exp_l.line, line_index_i);
          check_field("access_total", exp_l.accesses, access_total_i);
          check_field("miss_total", exp_l.misses, miss_total_i);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_OFFSET_BITS) begin
          if (cfg_data_i < OFF_MIN) offset_bits = CFG_W'(OFF_MIN);
          else if (cfg_data_i > OFF_MAX) offset_bits = CFG_W'(OFF_MAX);
          else offset_bits = cfg_data_i;
        end else begin
          if (cfg_data_i > IDX_MAX) index_bits = CFG_W'(IDX_MAX);
          else index_bits = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) expected_lookups.push_back(predict_lookup(address_i));
      outstanding = expected_lookups.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import dmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 240;
  localparam int RECENT_DEPTH   = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [IDX_W-1:0]   line_index_o;
  logic [COUNT_W-1:0] access_total_o;
  logic [COUNT_W-1:0] miss_total_o;

  int error_count;
  int pending;
  int result_count;
  int hit_count;
  int idle_cycles = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit hold_request = 1'b0;

  logic [CFG_W-1:0] phase_off[PHASES] = '{4'd8, 4'd4, 4'd6, 4'd3, 4'd8, 4'd5, 4'd7, 4'd4};
  logic [CFG_W-1:0] phase_idx[PHASES] = '{4'd10, 4'd0, 4'd11, 4'd5, 4'd1, 4'd10, 4'd3, 4'd10};
  logic [13:0]      tag_pool[4];
  logic [31:0]      recent_q[$];
  logic [31:0]      first_set[13] = '{
    32'h0000_0000, 32'h0000_000F, 32'h0000_0010, 32'h0000_3FF0, 32'h0000_4000,
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_3FF8, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hAAAA_AAA0, 32'h8000_0000
  };
  logic [31:0]      wide_block_set[5] = '{
    32'h0000_0000, 32'h0000_00FF, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FF00
  };
  logic [31:0]      back_set[3] = '{32'h0000_0010, 32'hFFFF_FFF0, 32'h8000_0000};

  direct_mapped_cache_hit_check uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .access_total_o (access_total_o),
    .miss_total_o   (miss_total_o)
  );

  dmc_lookup_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .address_i      (address_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_i          (hit_o),
    .line_index_i   (line_index_o),
    .access_total_i (access_total_o),
    .miss_total_i   (miss_total_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .hit_count_o    (hit_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each transfer unless rx_no_idle is set, one long hold-off on request
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = rx_no_idle ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  function automatic logic [31:0] next_address();
    int unsigned pick;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 45 && recent_q.size() > 0)
      a = recent_q[$urandom_range(0, recent_q.size() - 1)] ^ ($urandom & 32'hF);
    else if (pick < 80)
      a = {tag_pool[$urandom_range(0, 3)], 18'($urandom)};
    else
      a = $urandom;
    recent_q.push_back(a);
    if (recent_q.size() > RECENT_DEPTH) void'(recent_q.pop_front());
    return a;
  endfunction

  task automatic send_address(input logic [31:0] addr);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // drop valid and hold until every lookup has come back
  task automatic drain_lookups();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic program_split(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] idx);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_OFFSET_BITS;
    cfg_data_i <= off;
    @(negedge clk_i);
    cfg_idx_i <= REG_INDEX_BITS;
    cfg_data_i <= idx;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (first_set[i]) send_address(first_set[i]);
    drain_lookups();
    program_split(4'd15, 4'd0);
    foreach (wide_block_set[i]) send_address(wide_block_set[i]);
    drain_lookups();
    program_split(4'd0, 4'd15);
    foreach (back_set[i]) send_address(back_set[i]);
    drain_lookups();

    for (int p = 0; p < PHASES; p++) begin
      program_split(phase_off[p], phase_idx[p]);
      tx_no_idle = (p % 3 == 1);
      rx_no_idle = (p % 3 == 2);
      foreach (tag_pool[i]) tag_pool[i] = 14'($urandom);
      if (p == 2) begin
        tx_no_idle = 1'b1;
        hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) send_address(next_address());
      drain_lookups();
    end

    repeat (20) @(negedge clk_i);
    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d split settings,",
             result_count, hit_count, result_count - hit_count, PHASES + 3);
    $display("including clamped register values, random gaps and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dmc_pkg.sv
sv/dmc_ctrl.sv
sv/dmc_datapath.sv
sv/direct_mapped_cache_hit_check.sv
tb/dmc_lookup_checker.sv
tb/tb.sv
